/* rtl/kfsi_pkg.sv */
// Shared types and constants for the keyframe scale interpolator.
package kfsi_pkg;
  localparam int MaxKeys = 32;
  localparam int IdxW = $clog2(MaxKeys);
  localparam int CntW = IdxW + 1;
  localparam int FrameW = 32;
  localparam int ScaleW = 16;
  localparam logic signed [ScaleW-1:0] ScaleOne = 16'sd256;

  typedef enum logic [2:0] {
    CMD_INSERT = 3'd0,
    CMD_REMOVE = 3'd1,
    CMD_QUERY  = 3'd2,
    CMD_MOVE   = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_BAD_IDX  = 2'd2,
    ST_SAME     = 2'd3
  } result_code_t;

  typedef struct packed {
    logic [FrameW-1:0]        frame;
    logic signed [ScaleW-1:0] scale;
    logic                     locked;
  } key_t;

  // Per-cell shift control: 0 hold, 1 load from left, 2 load from right, 3 load new.
  typedef enum logic [1:0] {
    SH_HOLD  = 2'd0,
    SH_LEFT  = 2'd1,
    SH_RIGHT = 2'd2,
    SH_LOAD  = 2'd3
  } shop_t;

  typedef struct packed {
    logic            active;
    logic [CntW-1:0] lo;
    logic [CntW-1:0] hi;
  } span_t;
endpackage

/* rtl/kfsi_cell.sv */
// One table cell: holds a key and shifts to or from its neighbors.
module kfsi_cell (
  input  logic          clk,
  input  kfsi_pkg::shop_t op,
  input  kfsi_pkg::key_t  left_key,
  input  kfsi_pkg::key_t  right_key,
  input  kfsi_pkg::key_t  new_key,
  output kfsi_pkg::key_t  key
);
  import kfsi_pkg::*;
  key_t key_r;

  always_ff @(posedge clk) begin
    unique case (op)
      SH_HOLD:  key_r <= key_r;
      SH_LEFT:  key_r <= left_key;
      SH_RIGHT: key_r <= right_key;
      SH_LOAD:  key_r <= new_key;
      default:  key_r <= key_r;
    endcase
  end

  assign key = key_r;
endmodule

/* rtl/kfsi_div.sv */
// Serial restoring divider for the interpolation quotient.
module kfsi_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [47:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [47:0] quo
);
  import kfsi_pkg::*;
  logic [47:0] q_r, q_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [32:0] trial;

  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial = {rem_r[31:0], q_r[47]} - {1'b0, den};
    if (start) begin
      q_nxt = num;
      rem_nxt = '0;
      cnt_nxt = 6'd48;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[32]) begin
        rem_nxt = trial;
        q_nxt = {q_r[46:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[31:0], q_r[47]};
        q_nxt = {q_r[46:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign quo = q_r;
endmodule

/* rtl/keyframe_scale_interpolator.sv */
// Top level: keyframe table control, binary search and interpolation.
// Input channel (in_valid/in_ready) takes one command transaction: insert,
// remove, query, move or clear, with frame, scale, lock flag and index.
// Result channel (out_valid/out_ready) returns one transaction per command:
// status, position, interpolated scale and key count.
// Keys live in a row of 32 cells that each load from a neighbor or from the
// new key; an edit shifts the whole range at once.
// Binary search makes up to 6 probes, then the command is dispatched.
// Insert, remove, clear and a query that needs no division answer from the
// dispatch step; move adds a second step that shifts the moved key.
// A query between two keys adds a preparation step, a multiply step, a
// 48-step serial divider and a sign fix.
// One command is worked at a time; in_ready returns high the cycle after
// the result is taken. When the receiver stalls, the result stays in the
// output register and the block waits. Reset empties the table (count zero)
// and drops any pending result; cell contents are left as they were.
module keyframe_scale_interpolator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [2:0]                    in_cmd,
  input  logic [kfsi_pkg::FrameW-1:0]   in_frame,
  input  logic signed [kfsi_pkg::ScaleW-1:0] in_scale_in,
  input  logic                          in_locked_in,
  input  logic [kfsi_pkg::IdxW-1:0]     in_key_index,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_status,
  output logic [kfsi_pkg::CntW-1:0]     out_position,
  output logic signed [kfsi_pkg::ScaleW-1:0] out_scale_out,
  output logic [kfsi_pkg::CntW-1:0]     out_count
);
  import kfsi_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_SEARCH = 9'b000000010,
    S_DISP   = 9'b000000100,
    S_MOVE1  = 9'b000001000,
    S_QPREP  = 9'b000010000,
    S_QMUL   = 9'b000100000,
    S_QDIV   = 9'b001000000,
    S_QFIX   = 9'b010000000,
    S_OUT    = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic [2:0]            cmd_r;
  logic [FrameW-1:0]     frame_r;
  logic signed [ScaleW-1:0] scale_r;
  logic                  lock_r;
  logic [IdxW-1:0]       idx_r;
  logic [CntW-1:0]       count_r, count_nxt;
  span_t                 span_r, span_nxt;
  logic [1:0]            st_r, st_nxt;
  logic [CntW-1:0]       pos_r, pos_nxt;
  logic signed [ScaleW-1:0] sc_r, sc_nxt;
  logic [CntW-1:0]       ni_r, ni_nxt;
  key_t                  mkey_r, mkey_nxt;
  logic signed [16:0]    sd_r, sd_nxt;
  logic [31:0]           fd_r, fd_nxt;
  logic [31:0]           fo_r, fo_nxt;
  logic                  neg_r, neg_nxt;
  logic [47:0]           mag;
  logic signed [ScaleW-1:0] base_r, base_nxt;

  key_t  keys   [MaxKeys];
  shop_t ops    [MaxKeys];
  key_t  new_key;
  logic  div_start, div_done;
  logic [47:0] div_quo;

  logic [CntW-1:0] mid;
  key_t            mid_key;
  logic [IdxW-1:0] ub_i, b_i;
  key_t            ka, kb;
  logic signed [49:0] prod;
  logic signed [49:0] qs;

  for (genvar g = 0; g < MaxKeys; g++) begin : g_cell
    key_t lk, rk;
    if (g == 0) begin : g_l
      assign lk = new_key;
    end else begin : g_l
      assign lk = keys[g-1];
    end
    if (g == MaxKeys - 1) begin : g_r
      assign rk = new_key;
    end else begin : g_r
      assign rk = keys[g+1];
    end
    kfsi_cell u_cell (
      .clk       (clk),
      .op        (ops[g]),
      .left_key  (lk),
      .right_key (rk),
      .new_key   (new_key),
      .key       (keys[g])
    );
  end

  kfsi_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (mag),
    .den   (fd_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign mid     = CntW'((span_r.lo + span_r.hi) >> 1);
  assign mid_key = keys[mid[IdxW-1:0]];
  assign ub_i    = span_r.lo[IdxW-1:0];
  assign b_i     = IdxW'(span_r.lo - CntW'(1));
  assign ka      = keys[ub_i];
  assign kb      = keys[b_i];
  assign prod    = 50'(sd_r) * $signed({18'd0, fo_r});
  assign mag     = prod[49] ? 48'(-prod) : prod[47:0];
  assign qs      = neg_r ? -$signed({2'b00, div_quo}) : $signed({2'b00, div_quo});
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign div_start = (state_r == S_QMUL);

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    span_nxt = span_r;
    st_nxt = st_r;
    pos_nxt = pos_r;
    sc_nxt = sc_r;
    ni_nxt = ni_r;
    mkey_nxt = mkey_r;
    sd_nxt = sd_r;
    fd_nxt = fd_r;
    fo_nxt = fo_r;
    neg_nxt = neg_r;
    base_nxt = base_r;
    new_key = '{frame: frame_r, scale: scale_r, locked: lock_r};
    for (int i = 0; i < MaxKeys; i++) ops[i] = SH_HOLD;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          st_nxt = ST_OK;
          pos_nxt = '0;
          sc_nxt = '0;
          span_nxt = '{active: 1'b1, lo: '0, hi: count_r};
          state_nxt = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (span_r.lo < span_r.hi) begin
          if (frame_r < mid_key.frame) span_nxt.hi = mid;
          else span_nxt.lo = mid + CntW'(1);
        end else begin
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        state_nxt = S_OUT;
        unique case (cmd_r)
          CMD_INSERT: begin
            if (count_r >= CntW'(MaxKeys)) st_nxt = ST_FULL;
            else begin
              for (int i = 0; i < MaxKeys; i++) begin
                if (CntW'(i) == span_r.lo) ops[i] = SH_LOAD;
                else if (CntW'(i) > span_r.lo && CntW'(i) <= count_r) ops[i] = SH_LEFT;
              end
              pos_nxt = span_r.lo;
              count_nxt = count_r + CntW'(1);
            end
          end
          CMD_REMOVE: begin
            if (CntW'(idx_r) >= count_r) st_nxt = ST_BAD_IDX;
            else begin
              for (int i = 0; i < MaxKeys - 1; i++)
                if (i >= int'(idx_r) && CntW'(i + 1) < count_r) ops[i] = SH_RIGHT;
              pos_nxt = CntW'(idx_r);
              count_nxt = count_r - CntW'(1);
            end
          end
          CMD_MOVE: begin
            if (CntW'(idx_r) >= count_r) st_nxt = ST_BAD_IDX;
            else if (keys[idx_r].locked || keys[idx_r].frame == frame_r) begin
              st_nxt = ST_SAME;
              pos_nxt = CntW'(idx_r);
            end else begin
              ni_nxt = (span_r.lo > CntW'(idx_r)) ? span_r.lo - CntW'(1) : span_r.lo;
              mkey_nxt = '{frame: frame_r, scale: keys[idx_r].scale,
                           locked: keys[idx_r].locked};
              new_key = mkey_nxt;
              ops[idx_r] = SH_LOAD;
              pos_nxt = CntW'(idx_r);
              state_nxt = S_MOVE1;
            end
          end
          CMD_QUERY: begin
            if (count_r == '0) sc_nxt = ScaleOne;
            else if (span_r.lo == '0) sc_nxt = keys[0].scale;
            else if (kb.frame == frame_r || span_r.lo >= count_r) sc_nxt = kb.scale;
            else state_nxt = S_QPREP;
          end
          CMD_CLEAR: count_nxt = '0;
          default: ;
        endcase
      end
      S_MOVE1: begin
        if (ni_r != CntW'(idx_r) && keys[ni_r[IdxW-1:0]].frame != frame_r) begin
          new_key = mkey_r;
          for (int i = 0; i < MaxKeys; i++) begin
            if (CntW'(i) == ni_r) ops[i] = SH_LOAD;
            else if (ni_r < CntW'(idx_r) && CntW'(i) > ni_r && i <= int'(idx_r))
              ops[i] = SH_LEFT;
            else if (ni_r > CntW'(idx_r) && i >= int'(idx_r) && CntW'(i) < ni_r)
              ops[i] = SH_RIGHT;
          end
          pos_nxt = ni_r;
        end
        state_nxt = S_OUT;
      end
      S_QPREP: begin
        sd_nxt = 17'(ka.scale) - 17'(kb.scale);
        fd_nxt = ka.frame - kb.frame;
        fo_nxt = frame_r - kb.frame;
        base_nxt = kb.scale;
        state_nxt = (ka.frame == kb.frame) ? S_OUT : S_QMUL;
        if (ka.frame == kb.frame) sc_nxt = kb.scale;
      end
      S_QMUL: begin
        neg_nxt = prod[49];
        state_nxt = S_QDIV;
      end
      S_QDIV: begin
        if (div_done) state_nxt = S_QFIX;
      end
      S_QFIX: begin
        sc_nxt = ScaleW'(50'(base_r) + qs);
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      span_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      span_r <= span_nxt;
    end
    if (state_r == S_IDLE && in_valid) begin
      cmd_r <= in_cmd;
      frame_r <= in_frame;
      scale_r <= in_scale_in;
      lock_r <= in_locked_in;
      idx_r <= in_key_index;
    end
    st_r <= st_nxt;
    pos_r <= pos_nxt;
    sc_r <= sc_nxt;
    ni_r <= ni_nxt;
    mkey_r <= mkey_nxt;
    sd_r <= sd_nxt;
    fd_r <= fd_nxt;
    fo_r <= fo_nxt;
    neg_r <= neg_nxt;
    base_r <= base_nxt;
  end

  assign out_status   = st_r;
  assign out_position = pos_r;
  assign out_scale_out = sc_r;
  assign out_count    = count_r;
endmodule

/* verif/testbench.sv */
// Self-checking testbench for the keyframe scale interpolator.
`timescale 1ns / 1ps

module testbench;
  import kfsi_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] in_cmd = '0;
  logic [FrameW-1:0] in_frame = '0;
  logic signed [ScaleW-1:0] in_scale_in = '0;
  logic in_locked_in = 1'b0;
  logic [IdxW-1:0] in_key_index = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_status;
  logic [CntW-1:0] out_position;
  logic signed [ScaleW-1:0] out_scale_out;
  logic [CntW-1:0] out_count;

  keyframe_scale_interpolator dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  typedef struct packed {
    logic [1:0] status;
    logic [CntW-1:0] position;
    logic signed [ScaleW-1:0] scale;
    logic [CntW-1:0] count;
  } answer_t;

  typedef struct {
    logic [2:0] cmd;
    logic [FrameW-1:0] frame;
    logic signed [ScaleW-1:0] scale;
    logic locked;
    logic [IdxW-1:0] idx;
    bit typed;
    answer_t want;
  } row_t;

  key_t table_keys[MaxKeys];
  int unsigned num_keys;
  answer_t pending_answers[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_off = 1'b0;

  function automatic int unsigned find_after(logic [FrameW-1:0] f);
    int unsigned lo, hi, mid;
    lo = 0;
    hi = num_keys;
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      if (f < table_keys[mid].frame) hi = mid;
      else lo = mid + 1;
    end
    return lo;
  endfunction

  function automatic logic signed [ScaleW-1:0] scale_at_frame(logic [FrameW-1:0] f);
    int unsigned ub;
    longint sd, fd, num;
    if (num_keys == 0) return ScaleOne;
    ub = find_after(f);
    if (ub == 0) return table_keys[0].scale;
    if (table_keys[ub-1].frame == f || ub >= num_keys) return table_keys[ub-1].scale;
    sd = longint'(table_keys[ub].scale) - longint'(table_keys[ub-1].scale);
    fd = longint'({32'd0, table_keys[ub].frame}) - longint'({32'd0, table_keys[ub-1].frame});
    num = sd * (longint'({32'd0, f}) - longint'({32'd0, table_keys[ub-1].frame}));
    if (fd == 0) return table_keys[ub-1].scale;
    return ScaleW'(longint'(table_keys[ub-1].scale) + num / fd);
  endfunction

  function automatic answer_t apply_command(logic [2:0] cmd, logic [FrameW-1:0] f,
                                            logic signed [ScaleW-1:0] s, logic lk,
                                            logic [IdxW-1:0] idx);
    answer_t a;
    int unsigned p, ni;
    key_t mk;
    a = '0;
    case (cmd)
      CMD_INSERT: begin
        if (num_keys >= MaxKeys) a.status = ST_FULL;
        else begin
          p = find_after(f);
          for (int i = num_keys; i > p; i--) table_keys[i] = table_keys[i-1];
          table_keys[p] = '{frame: f, scale: s, locked: lk};
          num_keys++;
          a.position = CntW'(p);
        end
      end
      CMD_REMOVE: begin
        if (idx >= num_keys) a.status = ST_BAD_IDX;
        else begin
          for (int i = idx; i + 1 < num_keys; i++) table_keys[i] = table_keys[i+1];
          num_keys--;
          a.position = CntW'(idx);
        end
      end
      CMD_QUERY: a.scale = scale_at_frame(f);
      CMD_MOVE: begin
        if (idx >= num_keys) a.status = ST_BAD_IDX;
        else if (table_keys[idx].locked || table_keys[idx].frame == f) begin
          a.status = ST_SAME;
          a.position = CntW'(idx);
        end else begin
          ni = find_after(f);
          if (ni > idx) ni--;
          table_keys[idx].frame = f;
          a.position = CntW'(idx);
          if (ni != idx && table_keys[ni].frame != f) begin
            mk = table_keys[idx];
            if (ni < idx) for (int i = idx; i > ni; i--) table_keys[i] = table_keys[i-1];
            else for (int i = idx; i < ni; i++) table_keys[i] = table_keys[i+1];
            table_keys[ni] = mk;
            a.position = CntW'(ni);
          end
        end
      end
      CMD_CLEAR: num_keys = 0;
      default: ;
    endcase
    a.count = CntW'(num_keys);
    return a;
  endfunction

  task automatic send_command(logic [2:0] cmd, logic [FrameW-1:0] f,
                              logic signed [ScaleW-1:0] s, logic lk,
                              logic [IdxW-1:0] idx, bit typed, answer_t want);
    answer_t a;
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_frame <= f;
    in_scale_in <= s;
    in_locked_in <= lk;
    in_key_index <= idx;
    do @(posedge clk); while (!in_ready);
    a = apply_command(cmd, f, s, lk, idx);
    if (typed && a != want) begin
      $error("table row expectation %h differs from prediction %h", want, a);
      errors++;
    end
    pending_answers.push_back(typed ? want : a);
    @(negedge clk);
  endtask

  function automatic logic [FrameW-1:0] pick_frame();
    case ($urandom_range(3))
      0: return $urandom_range(40);
      1: return $urandom;
      2: return 32'hFFFF_FFFF - $urandom_range(3);
      default: return (num_keys > 0) ? table_keys[$urandom_range(num_keys-1)].frame
                                     : $urandom_range(1000);
    endcase
  endfunction

  task automatic send_random();
    int r;
    logic [2:0] cmd;
    logic [IdxW-1:0] idx;
    r = $urandom_range(99);
    if (r < 35) cmd = CMD_INSERT;
    else if (r < 47) cmd = CMD_REMOVE;
    else if (r < 77) cmd = CMD_QUERY;
    else if (r < 94) cmd = CMD_MOVE;
    else if (r < 97) cmd = CMD_CLEAR;
    else cmd = 3'($urandom_range(7, 5));
    idx = ($urandom_range(9) == 0 || num_keys == 0) ? IdxW'($urandom)
          : IdxW'($urandom_range(num_keys-1));
    send_command(cmd, pick_frame(), ScaleW'($urandom), $urandom_range(3) == 0, idx,
                 1'b0, '0);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(negedge clk);
  endtask

  always @(negedge clk) begin
    out_ready <= !hold_off &&
                 !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    answer_t w;
    if (rst_n && out_valid && out_ready) begin
      if (pending_answers.size() == 0) begin
        $error("result transaction with nothing expected");
        errors++;
      end else begin
        w = pending_answers.pop_front();
        if (out_status != w.status) begin
          $error("status: expected %0d, got %0d", w.status, out_status); errors++;
        end
        if (out_position != w.position) begin
          $error("position: expected %0d, got %0d", w.position, out_position); errors++;
        end
        if (out_scale_out != w.scale) begin
          $error("scale_out: expected %0d, got %0d", w.scale, out_scale_out); errors++;
        end
        if (out_count != w.count) begin
          $error("count: expected %0d, got %0d", w.count, out_count); errors++;
        end
      end
    end
  end

  row_t directed[$];

  function automatic row_t mk_row(logic [2:0] c, logic [FrameW-1:0] f,
                                  logic signed [ScaleW-1:0] s, logic lk,
                                  logic [IdxW-1:0] i, bit t, answer_t w);
    row_t r;
    r.cmd = c; r.frame = f; r.scale = s; r.locked = lk; r.idx = i; r.typed = t; r.want = w;
    return r;
  endfunction

  initial begin
    directed.push_back(mk_row(CMD_QUERY, 32'd5, 0, 0, 0, 1, '{ST_OK, 0, ScaleOne, 0}));
    directed.push_back(mk_row(CMD_REMOVE, 0, 0, 0, 0, 1, '{ST_BAD_IDX, 0, 0, 0}));
    directed.push_back(mk_row(CMD_MOVE, 0, 0, 0, 5'd31, 1, '{ST_BAD_IDX, 0, 0, 0}));
    directed.push_back(mk_row(CMD_INSERT, 32'd100, 16'sh7FFF, 0, 0, 1, '{ST_OK, 0, 0, 1}));
    directed.push_back(mk_row(CMD_INSERT, 32'd0, -16'sh8000, 1, 0, 1, '{ST_OK, 0, 0, 2}));
    directed.push_back(mk_row(CMD_INSERT, 32'hFFFF_FFFF, 16'sd256, 0, 0, 1,
                              '{ST_OK, 2, 0, 3}));
    directed.push_back(mk_row(CMD_INSERT, 32'd100, 16'sd512, 0, 0, 1, '{ST_OK, 2, 0, 4}));
    directed.push_back(mk_row(CMD_QUERY, 32'd50, 0, 0, 0, 0, '0));
    directed.push_back(mk_row(CMD_QUERY, 32'hFFFF_FFFF, 0, 0, 0, 1, '{ST_OK, 0, 256, 4}));
    directed.push_back(mk_row(CMD_QUERY, 32'h8000_0000, 0, 0, 0, 0, '0));
    directed.push_back(mk_row(CMD_MOVE, 32'd7, 0, 0, 0, 1, '{ST_SAME, 0, 0, 4}));
    directed.push_back(mk_row(CMD_MOVE, 32'd100, 0, 0, 1, 1, '{ST_SAME, 1, 0, 4}));
    directed.push_back(mk_row(CMD_MOVE, 32'd100, 0, 0, 3, 0, '0));
    directed.push_back(mk_row(CMD_MOVE, 32'd1, 0, 0, 3, 0, '0));
    directed.push_back(mk_row(CMD_MOVE, 32'hFFFF_FFF0, 0, 0, 1, 0, '0));
    directed.push_back(mk_row(3'd7, 0, 0, 0, 0, 1, '{ST_OK, 0, 0, 4}));
    directed.push_back(mk_row(CMD_REMOVE, 0, 0, 0, 0, 1, '{ST_OK, 0, 0, 3}));
    directed.push_back(mk_row(CMD_QUERY, 32'd0, 0, 0, 0, 0, '0));
    directed.push_back(mk_row(CMD_CLEAR, 0, 0, 0, 0, 1, '{ST_OK, 0, 0, 0}));
    for (int i = 0; i < 32; i++)
      directed.push_back(mk_row(CMD_INSERT, 32'(i * 3), 16'(i * 40 - 600), i[0], 0, 0, '0));
    directed.push_back(mk_row(CMD_INSERT, 32'd9, 0, 0, 0, 1, '{ST_FULL, 0, 0, 32}));
    directed.push_back(mk_row(CMD_REMOVE, 0, 0, 0, 5'd31, 1, '{ST_OK, 31, 0, 31}));
  end

  initial begin
    num_keys = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    foreach (directed[i])
      send_command(directed[i].cmd, directed[i].frame, directed[i].scale,
                   directed[i].locked, directed[i].idx, directed[i].typed, directed[i].want);
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
        3: begin send_idle_pct = 14; recv_stall_pct = 14; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      if (ph == 4) fork
        begin
          hold_off = 1'b1;
          repeat (400) @(negedge clk);
          hold_off = 1'b0;
        end
      join_none
      for (int n = 0; n < 225; n++) send_random();
      wait_drained();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (100) @(negedge clk);
    if (errors == 0 && pending_answers.size() == 0)
      $display("keyframe_scale_interpolator test passed");
    else
      $display("keyframe_scale_interpolator test failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("keyframe_scale_interpolator test failed");
    $finish;
  end
endmodule
